FILE: hdl/rotation_matrix_to_quaternion_core_defines.svh
// Assertion macros shared by the rotation matrix to quaternion RTL.
// No dependencies; include by bare file name.
`ifndef ROTATION_MATRIX_TO_QUATERNION_CORE_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_CORE_DEFINES_SVH

// Implication checked while out of reset.
`define RMQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rmq assertion failed");

// Next-cycle implication, also checked during reset.
`define RMQ_ASSERT_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("rmq assertion failed");

`endif

FILE: hdl/rmq_pkg.sv
// Shared types and constants for the rotation matrix to quaternion core.
// No dependencies.
`default_nettype none

package rmq_pkg;

    localparam int FRAC_BITS_DEF = 14;
    localparam int DW            = 16;
    localparam int DIFF_W        = 18;

    typedef enum logic [1:0] {
        BR_TRACE,
        BR_X,
        BR_Y,
        BR_Z
    } t_branch;

    typedef struct packed {
        t_branch br;
        logic    inv;
    } t_side;

endpackage

`default_nettype wire

FILE: hdl/rmq_front.sv
// Front stage: trace, branch pick, square-root argument and the three
// off-diagonal sums or differences per branch. Depends on rmq_pkg.
`default_nettype none

module rmq_front #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF,
    parameter int AW        = 19
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_vld,
    input  logic signed [rmq_pkg::DW-1:0]     i_m00,
    input  logic signed [rmq_pkg::DW-1:0]     i_m01,
    input  logic signed [rmq_pkg::DW-1:0]     i_m02,
    input  logic signed [rmq_pkg::DW-1:0]     i_m10,
    input  logic signed [rmq_pkg::DW-1:0]     i_m11,
    input  logic signed [rmq_pkg::DW-1:0]     i_m12,
    input  logic signed [rmq_pkg::DW-1:0]     i_m20,
    input  logic signed [rmq_pkg::DW-1:0]     i_m21,
    input  logic signed [rmq_pkg::DW-1:0]     i_m22,
    output logic                              o_vld,
    output rmq_pkg::t_side                    o_side,
    output logic [AW-2:0]                     o_arg,
    output logic signed [rmq_pkg::DIFF_W-1:0] o_d0,
    output logic signed [rmq_pkg::DIFF_W-1:0] o_d1,
    output logic signed [rmq_pkg::DIFF_W-1:0] o_d2
);
    import rmq_pkg::*;

    localparam logic signed [AW-1:0] ONE = {{(AW-1){1'b0}}, 1'b1} << FRAC_BITS;

    logic signed [AW-1:0]     e00, e11, e22, tr, arg;
    logic signed [DIFF_W-1:0] d_a, d_b, d_c, d_xy, d_xz, d_yz;
    t_side                    n_side;
    logic signed [DIFF_W-1:0] n_d0, n_d1, n_d2;

    logic                     r_vld;
    t_side                    r_side;
    logic [AW-2:0]            r_arg;
    logic signed [DIFF_W-1:0] r_d0, r_d1, r_d2;

    always_comb begin
        e00  = AW'(i_m00);
        e11  = AW'(i_m11);
        e22  = AW'(i_m22);
        tr   = e00 + e11 + e22;
        d_a  = DIFF_W'(i_m21) - DIFF_W'(i_m12);
        d_b  = DIFF_W'(i_m02) - DIFF_W'(i_m20);
        d_c  = DIFF_W'(i_m10) - DIFF_W'(i_m01);
        d_xy = DIFF_W'(i_m01) + DIFF_W'(i_m10);
        d_xz = DIFF_W'(i_m02) + DIFF_W'(i_m20);
        d_yz = DIFF_W'(i_m12) + DIFF_W'(i_m21);
        if (tr > 0) begin
            n_side.br = BR_TRACE;
            arg       = ONE + tr;
        end else if (i_m00 > i_m11 && i_m00 > i_m22) begin
            n_side.br = BR_X;
            arg       = ONE + e00 - e11 - e22;
        end else if (i_m11 > i_m22) begin
            n_side.br = BR_Y;
            arg       = ONE + e11 - e00 - e22;
        end else begin
            n_side.br = BR_Z;
            arg       = ONE + e22 - e00 - e11;
        end
        n_side.inv = (arg <= 0);
        case (n_side.br)
            BR_TRACE: begin
                n_d0 = d_a; n_d1 = d_b;  n_d2 = d_c;
            end
            BR_X: begin
                n_d0 = d_a; n_d1 = d_xy; n_d2 = d_xz;
            end
            BR_Y: begin
                n_d0 = d_b; n_d1 = d_xy; n_d2 = d_yz;
            end
            default: begin
                n_d0 = d_c; n_d1 = d_xz; n_d2 = d_yz;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= n_side;
            r_arg  <= arg[AW-2:0];
            r_d0   <= n_d0;
            r_d1   <= n_d1;
            r_d2   <= n_d2;
        end
    end

    assign o_vld  = r_vld;
    assign o_side = r_side;
    assign o_arg  = r_arg;
    assign o_d0   = r_d0;
    assign o_d1   = r_d1;
    assign o_d2   = r_d2;

endmodule

`default_nettype wire

FILE: hdl/rmq_sqrt.sv
// Pipelined integer square root of (arg << FRAC_BITS), one root bit per
// stage, with a sideband carried alongside. Depends on rmq_pkg.
`default_nettype none

module rmq_sqrt #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF,
    parameter int AW        = 19,
    parameter int SW        = 8,
    parameter int RW        = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  logic [AW-2:0] i_arg,
    input  logic [SW-1:0] i_side,
    output logic          o_vld,
    output logic [RW-1:0] o_root,
    output logic [SW-1:0] o_side
);
    import rmq_pkg::*;

    localparam int PW  = 2 * RW;
    localparam int RMW = RW + 3;

    logic          r_vld  [RW];
    logic [PW-1:0] r_n    [RW];
    logic [RMW-1:0] r_rem [RW];
    logic [RW-1:0] r_root [RW];
    logic [SW-1:0] r_side [RW];

    for (genvar g = 0; g < RW; g++) begin : g_stage
        logic           p_vld;
        logic [PW-1:0]  p_n;
        logic [RMW-1:0] p_rem;
        logic [RW-1:0]  p_root;
        logic [SW-1:0]  p_side;
        logic [RMW-1:0] rs, trial, n_rem;
        logic [RW-1:0]  n_root;
        logic           ge;

        if (g == 0) begin : g_first
            assign p_vld  = i_vld;
            assign p_n    = PW'(i_arg) << FRAC_BITS;
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_side = i_side;
        end else begin : g_rest
            assign p_vld  = r_vld[g-1];
            assign p_n    = r_n[g-1];
            assign p_rem  = r_rem[g-1];
            assign p_root = r_root[g-1];
            assign p_side = r_side[g-1];
        end

        always_comb begin
            rs     = {p_rem[RMW-3:0], p_n[PW-1:PW-2]};
            trial  = RMW'({p_root, 2'b01});
            ge     = (rs >= trial);
            n_rem  = ge ? (rs - trial) : rs;
            n_root = {p_root[RW-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n[g]    <= p_n << 2;
                r_rem[g]  <= n_rem;
                r_root[g] <= n_root;
                r_side[g] <= p_side;
            end
        end
    end

    assign o_vld  = r_vld[RW-1];
    assign o_root = r_root[RW-1];
    assign o_side = r_side[RW-1];

endmodule

`default_nettype wire

FILE: hdl/rmq_div.sv
// Pipelined rounded divide d * ONE / (2r) with 16-bit saturation:
// one setup stage, then one quotient bit per stage. Depends on rmq_pkg.
`default_nettype none

module rmq_div #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF,
    parameter int RW        = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_vld,
    input  logic signed [rmq_pkg::DIFF_W-1:0] i_d,
    input  logic [RW-1:0]                     i_root,
    output logic                              o_vld,
    output logic signed [rmq_pkg::DW-1:0]     o_q
);
    import rmq_pkg::*;

    localparam int NUMW = ((17 + FRAC_BITS > RW) ? 17 + FRAC_BITS : RW) + 1;
    localparam int CW   = ((NUMW > RW + DW) ? NUMW : RW + DW) + 1;
    localparam int NST  = DW;

    logic              r_vld [NST+1];
    logic              r_neg [NST+1];
    logic [CW-1:0]     r_rem [NST+1];
    logic [RW:0]       r_den [NST+1];
    logic [DW-1:0]     r_q   [NST+1];

    logic [DIFF_W-1:0] mag;
    logic              ovf;
    logic [DW-1:0]     qmag;

    assign mag = i_d[DIFF_W-1] ? DIFF_W'(-i_d) : DIFF_W'(i_d);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg[0] <= i_d[DIFF_W-1];
            r_rem[0] <= (CW'(mag) << FRAC_BITS) + CW'(i_root);
            r_den[0] <= {i_root, 1'b0};
            r_q[0]   <= '0;
        end
    end

    for (genvar s = 1; s <= NST; s++) begin : g_step
        logic [CW-1:0] dsh;
        logic          ge;

        assign dsh = CW'(r_den[s-1]) << (NST - s);
        assign ge  = (r_rem[s-1] >= dsh);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= r_vld[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_neg[s] <= r_neg[s-1];
                r_rem[s] <= ge ? (r_rem[s-1] - dsh) : r_rem[s-1];
                r_den[s] <= r_den[s-1];
                r_q[s]   <= {r_q[s-1][DW-2:0], ge};
            end
        end
    end

    // Top quotient bit set means the magnitude reached 2^15: saturate.
    always_comb begin
        ovf  = r_q[NST][DW-1];
        qmag = {1'b0, r_q[NST][DW-2:0]};
        if (r_neg[NST]) begin
            o_q = ovf ? $signed({1'b1, {(DW-1){1'b0}}}) : $signed(-qmag);
        end else begin
            o_q = ovf ? $signed({1'b0, {(DW-1){1'b1}}}) : $signed(qmag);
        end
    end

    assign o_vld = r_vld[NST];

endmodule

`default_nettype wire

FILE: hdl/rotation_matrix_to_quaternion_core.sv
// Path from input to output transaction: front register, square-root pipe of
// RW = (max(FRAC_BITS,17) + 1 + FRAC_BITS + 1) / 2 root bits, dividers, output register.
// Throughput: one transaction per cycle unless held (full output, sink not ready);
// the square-root pipe (one root bit per stage) and three 17-stage divider pipes set the depth, not the rate.
// Reset: synchronous active-low i_rst_n clears every valid bit; data regs hold.
`default_nettype none
`include "rotation_matrix_to_quaternion_core_defines.svh"

module rotation_matrix_to_quaternion_core #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [rmq_pkg::DW-1:0] i_m00,
    input  logic signed [rmq_pkg::DW-1:0] i_m01,
    input  logic signed [rmq_pkg::DW-1:0] i_m02,
    input  logic signed [rmq_pkg::DW-1:0] i_m10,
    input  logic signed [rmq_pkg::DW-1:0] i_m11,
    input  logic signed [rmq_pkg::DW-1:0] i_m12,
    input  logic signed [rmq_pkg::DW-1:0] i_m20,
    input  logic signed [rmq_pkg::DW-1:0] i_m21,
    input  logic signed [rmq_pkg::DW-1:0] i_m22,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [rmq_pkg::DW-1:0] o_qw,
    output logic signed [rmq_pkg::DW-1:0] o_qx,
    output logic signed [rmq_pkg::DW-1:0] o_qy,
    output logic signed [rmq_pkg::DW-1:0] o_qz,
    output logic                          o_invalid
);
    import rmq_pkg::*;

    // Argument width: ONE plus up to three full-scale entries, with sign.
    localparam int AW  = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
    localparam int NW  = AW - 1 + FRAC_BITS;
    localparam int RW  = (NW + 1) / 2;
    localparam int SW  = $bits(t_side) + 3 * DIFF_W;
    localparam int DLY = DW + 1;

    // Identity scalar: ONE, clipped to 16 bits for wide fraction formats.
    localparam logic signed [DW-1:0] ONE16 =
        (FRAC_BITS >= DW - 1) ? $signed({1'b0, {(DW-1){1'b1}}})
                              : $signed(DW'(1) << FRAC_BITS);

    // Whole pipe advances together; it only holds when the output
    // register is full and the sink is not taking it.
    logic en;

    logic                     f_vld;
    t_side                    f_side;
    logic [AW-2:0]            f_arg;
    logic signed [DIFF_W-1:0] f_d0, f_d1, f_d2;

    logic                     s_vld;
    logic [RW-1:0]            s_root;
    logic [SW-1:0]            s_side_bus;
    t_side                    s_side;
    logic signed [DIFF_W-1:0] s_d0, s_d1, s_d2;
    logic [RW:0]              s_hsum;
    logic signed [DW-1:0]     s_half;

    logic                     q_vld0, q_vld1, q_vld2;
    logic signed [DW-1:0]     q0, q1, q2;

    t_side                    r_dl_side [DLY];
    logic signed [DW-1:0]     r_dl_half [DLY];

    logic                     r_out_vld;
    logic signed [DW-1:0]     r_qw, r_qx, r_qy, r_qz;
    logic                     r_inv;
    logic signed [DW-1:0]     n_qw, n_qx, n_qy, n_qz;
    t_side                    t_fin;

    assign en      = !r_out_vld || i_ready;
    assign o_ready = en;

    // Stage 1: branch selection, square-root argument and off-diagonal sums.
    rmq_front #(
        .FRAC_BITS (FRAC_BITS),
        .AW        (AW)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_valid),
        .i_m00   (i_m00),
        .i_m01   (i_m01),
        .i_m02   (i_m02),
        .i_m10   (i_m10),
        .i_m11   (i_m11),
        .i_m12   (i_m12),
        .i_m20   (i_m20),
        .i_m21   (i_m21),
        .i_m22   (i_m22),
        .o_vld   (f_vld),
        .o_side  (f_side),
        .o_arg   (f_arg),
        .o_d0    (f_d0),
        .o_d1    (f_d1),
        .o_d2    (f_d2)
    );

    // Square root; branch, invalid flag and the three sums or differences ride along.
    rmq_sqrt #(
        .FRAC_BITS (FRAC_BITS),
        .AW        (AW),
        .SW        (SW),
        .RW        (RW)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (f_vld),
        .i_arg   (f_arg),
        .i_side  ({f_side, f_d0, f_d1, f_d2}),
        .o_vld   (s_vld),
        .o_root  (s_root),
        .o_side  (s_side_bus)
    );

    assign {s_side, s_d0, s_d1, s_d2} = s_side_bus;

    // Component of the chosen branch: (r + 1) >> 1, clipped to 16 bits.
    always_comb begin
        s_hsum = {1'b0, s_root} + (RW+1)'(1);
        if (s_hsum[RW:1] > (RW)'(32767)) begin
            s_half = $signed({1'b0, {(DW-1){1'b1}}});
        end else begin
            s_half = $signed(DW'(s_hsum[RW:1]));
        end
    end

    // Three divider lanes: the off-diagonal sums or differences over 2r.
    rmq_div #(.FRAC_BITS (FRAC_BITS), .RW (RW)) u_div0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (s_vld),
        .i_d     (s_d0),
        .i_root  (s_root),
        .o_vld   (q_vld0),
        .o_q     (q0)
    );

    rmq_div #(.FRAC_BITS (FRAC_BITS), .RW (RW)) u_div1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (s_vld),
        .i_d     (s_d1),
        .i_root  (s_root),
        .o_vld   (q_vld1),
        .o_q     (q1)
    );

    rmq_div #(.FRAC_BITS (FRAC_BITS), .RW (RW)) u_div2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (s_vld),
        .i_d     (s_d2),
        .i_root  (s_root),
        .o_vld   (q_vld2),
        .o_q     (q2)
    );

    // Delay branch, invalid flag and half component to match the dividers.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dl_side[0] <= s_side;
            r_dl_half[0] <= s_half;
            for (int k = 1; k < DLY; k++) begin
                r_dl_side[k] <= r_dl_side[k-1];
                r_dl_half[k] <= r_dl_half[k-1];
            end
        end
    end

    // Place the half component at the branch slot, divider lanes in order
    // at the rest; a non-positive argument gives the identity.
    always_comb begin
        t_fin = r_dl_side[DLY-1];
        case (t_fin.br)
            BR_TRACE: begin
                n_qw = r_dl_half[DLY-1]; n_qx = q0; n_qy = q1; n_qz = q2;
            end
            BR_X: begin
                n_qw = q0; n_qx = r_dl_half[DLY-1]; n_qy = q1; n_qz = q2;
            end
            BR_Y: begin
                n_qw = q0; n_qx = q1; n_qy = r_dl_half[DLY-1]; n_qz = q2;
            end
            default: begin
                n_qw = q0; n_qx = q1; n_qy = q2; n_qz = r_dl_half[DLY-1];
            end
        endcase
        if (t_fin.inv) begin
            n_qw = ONE16;
            n_qx = '0;
            n_qy = '0;
            n_qz = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= q_vld0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_qw  <= n_qw;
            r_qx  <= n_qx;
            r_qy  <= n_qy;
            r_qz  <= n_qz;
            r_inv <= t_fin.inv;
        end
    end

    assign o_valid   = r_out_vld;
    assign o_qw      = r_qw;
    assign o_qx      = r_qx;
    assign o_qy      = r_qy;
    assign o_qz      = r_qz;
    assign o_invalid = r_inv;

    `RMQ_ASSERT_IMPL(a_lanes_aligned, i_clk, i_rst_n, q_vld0, q_vld1 && q_vld2)
    `RMQ_ASSERT_IMPL(a_root_nonzero, i_clk, i_rst_n, s_vld && !s_side.inv, s_root != '0)
    `RMQ_ASSERT_IMPL(a_ready_when_empty, i_clk, i_rst_n, !o_valid, o_ready)
    `RMQ_ASSERT_IMPL(a_identity, i_clk, i_rst_n, o_valid && o_invalid, o_qx == '0 && o_qy == '0 && o_qz == '0)
    `RMQ_ASSERT_NEXT(a_reset_empty, i_clk, !i_rst_n, !o_valid)

endmodule

`default_nettype wire
